/* rtl/frc_pkg.sv */
// ----------------------------------------------------------------------------
// FASTA reverse complement package
// Sizes, operation and status codes, and the command and status bundles
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package frc_pkg;

    // Sequence store: depth, address width and count width.
    localparam int SEQ_MAX = 65536;
    localparam int SEQ_AW  = $clog2(SEQ_MAX);
    localparam int SEQ_CW  = $clog2(SEQ_MAX + 1);

    // Record name store.
    localparam int NAME_MAX = 48;
    localparam int NAME_AW  = $clog2(NAME_MAX);
    localparam int NAME_CW  = $clog2(NAME_MAX + 1);

    // Line width register.
    localparam int              LW_W     = 6;
    localparam logic [LW_W-1:0] LW_RESET = 6'd60;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_PULL = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_BYTE      = 3'd1;
    localparam logic [2:0] ST_REFUSED   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FORMAT    = 3'd4;
    localparam logic [2:0] ST_SEQ_FULL  = 3'd5;
    localparam logic [2:0] ST_NAME_LONG = 3'd6;

    // Byte source of an emitted output byte.
    typedef logic [2:0] t_src;
    localparam t_src SRC_GT   = 3'd0;
    localparam t_src SRC_NAME = 3'd1;
    localparam t_src SRC_SFX  = 3'd2;
    localparam t_src SRC_SEQ  = 3'd3;
    localparam t_src SRC_NL   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic single;      // accept an item that yields one result
        logic pull_start;  // accept a pull and prime the store read
        logic emit;        // load one output byte from the selected source
        t_src sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
        logic error_flag;
        logic drain_active;
        logic header_sent;
        logic name_empty;
        logic name_end;
        logic sfx_end;
        logic line_end;
    } t_dp_sts;

endpackage

/* rtl/fasta_reverse_complement.sv */
// ----------------------------------------------------------------------------
// FASTA reverse complement
// Parses pushed FASTA text and emits each record reverse-complemented.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries an opcode and a data byte:
// push a text byte, mark end of input, or pull the next output line. Output
// channel (o_out_valid / i_out_stall) carries one result beat at a time.
// A push, an end of input, or a refused or empty pull gives one beat,
// registered in the cycle after acceptance; such items are taken back to back,
// one per cycle, as long as the output register drains.
// A pull of a line during a drain first primes the store read,
// then gives one beat per cycle: 11 + name length beats for the header
// line, line_width + 1 beats (fewer at the end) for a sequence line. The
// input is stalled until the last beat of the line is loaded.
// When the receiver stalls, the output register holds its beat and the
// line sequencer waits with it.
// The line width is written on the configuration channel, which is always
// ready; write it only while the block is idle. Reset sets the width to 60
// and waits for a first header; the stores need no clearing.
// ----------------------------------------------------------------------------
module fasta_reverse_complement (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_opcode,
    input  logic [7:0]               i_data_byte,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [7:0]               o_out_byte,
    output logic                     o_out_last,
    output logic [2:0]               o_status,
    output logic                     o_record_done,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [frc_pkg::LW_W-1:0] i_cfg_data
);

    import frc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    frc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    frc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_opcode),
        .i_data_byte   (i_data_byte),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_status      (o_status),
        .o_record_done (o_record_done)
    );

endmodule

/* rtl/frc_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module frc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/frc_ctrl.sv */
// ----------------------------------------------------------------------------
// FASTA reverse complement controller
// Accepts items and sequences the bytes of one output line per pull.
// ----------------------------------------------------------------------------
module frc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_opcode,
    input  frc_pkg::t_dp_sts i_sts,
    output frc_pkg::t_dp_cmd o_cmd,
    output logic             o_in_stall
);

    import frc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GT   = 3'd1;
    localparam logic [2:0] S_NAME = 3'd2;
    localparam logic [2:0] S_SFX  = 3'd3;
    localparam logic [2:0] S_SEQ  = 3'd4;
    localparam logic [2:0] S_NL   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.sel  = SRC_NL;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = !i_sts.slot_free;
                if (i_in_valid && i_sts.slot_free) begin
                    if (i_opcode == OP_PULL && !i_sts.error_flag && i_sts.drain_active) begin
                        o_cmd.pull_start = 1'b1;
                        n_state = i_sts.header_sent ? S_SEQ : S_GT;
                    end else begin
                        o_cmd.single = 1'b1;
                    end
                end
            end
            S_GT: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SRC_GT;
                    n_state    = i_sts.name_empty ? S_SFX : S_NAME;
                end
            end
            S_NAME: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SRC_NAME;
                    if (i_sts.name_end) begin
                        n_state = S_SFX;
                    end
                end
            end
            S_SFX: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SRC_SFX;
                    if (i_sts.sfx_end) begin
                        n_state = S_NL;
                    end
                end
            end
            S_SEQ: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SRC_SEQ;
                    if (i_sts.line_end) begin
                        n_state = S_NL;
                    end
                end
            end
            S_NL: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SRC_NL;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_line_needs_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> i_sts.drain_active)
        else $error("output line in progress without an active drain");

    a_seq_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEQ) |-> i_sts.header_sent)
        else $error("sequence line started before the header line");

    a_header_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GT || r_state == S_NAME || r_state == S_SFX) |-> !i_sts.header_sent)
        else $error("header line emitted twice for one record");
`endif

endmodule

/* rtl/frc_dp.sv */
// ----------------------------------------------------------------------------
// FASTA reverse complement datapath
// Parser state, name and sequence stores, drain pointers and output register.
// ----------------------------------------------------------------------------
module frc_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  frc_pkg::t_dp_cmd         i_cmd,
    output frc_pkg::t_dp_sts         o_sts,
    input  logic [1:0]               i_opcode,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_cfg_valid,
    input  logic [frc_pkg::LW_W-1:0] i_cfg_data,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic [7:0]               o_out_byte,
    output logic                     o_out_last,
    output logic [2:0]               o_status,
    output logic                     o_record_done
);

    import frc_pkg::*;

    localparam logic [2:0] PH_FIRST    = 3'd0;
    localparam logic [2:0] PH_HDR_PRE  = 3'd1;
    localparam logic [2:0] PH_HDR_NAME = 3'd2;
    localparam logic [2:0] PH_HDR_REST = 3'd3;
    localparam logic [2:0] PH_BODY     = 3'd4;
    localparam logic [2:0] PH_PENDING  = 3'd5;
    localparam logic [2:0] PH_ENDED    = 3'd6;

    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_NL = 8'h0A;

    localparam int SFX_LEN = 9;
    localparam int SFX_IW  = $clog2(SFX_LEN);

    function automatic logic [7:0] sfx_byte(input logic [SFX_IW-1:0] k);
        logic [7:0] b;
        unique case (k)
            SFX_IW'(0): b = 8'h20;  // space
            SFX_IW'(1): b = 8'h72;  // r
            SFX_IW'(2): b = 8'h65;  // e
            SFX_IW'(3): b = 8'h76;  // v
            SFX_IW'(4): b = 8'h63;  // c
            SFX_IW'(5): b = 8'h6F;  // o
            SFX_IW'(6): b = 8'h6D;  // m
            SFX_IW'(7): b = 8'h70;  // p
            default:    b = 8'h6C;  // l
        endcase
        return b;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic [7:0] complement_of(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] r;
        u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
        unique case (u)
            8'h41:   r = 8'h54;  // A to T
            8'h43:   r = 8'h47;  // C to G
            8'h47:   r = 8'h43;  // G to C
            8'h54:   r = 8'h41;  // T to A
            8'h4E:   r = 8'h4E;  // N stays
            8'h2D:   r = 8'h2D;  // gap stays
            default: r = 8'h3F;  // anything else becomes '?'
        endcase
        return r;
    endfunction

    // Control state.
    logic [LW_W-1:0]    r_lw, n_lw;
    logic [2:0]         r_phase, n_phase;
    logic               r_line_start, n_line_start;
    logic               r_seq_started, n_seq_started;
    logic [SEQ_CW-1:0]  r_seq_count, n_seq_count;
    logic [NAME_CW-1:0] r_name_count, n_name_count;
    logic               r_drain, n_drain;
    logic               r_hdr_sent, n_hdr_sent;
    logic [SEQ_CW-1:0]  r_rd_ptr, n_rd_ptr;
    logic               r_error, n_error;
    logic               r_out_valid, n_out_valid;

    // Payload state.
    logic [7:0]         r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;
    logic [2:0]         r_out_status, n_out_status;
    logic               r_out_done, n_out_done;
    logic [NAME_AW-1:0] r_name_idx, n_name_idx;
    logic [SFX_IW-1:0]  r_sfx_idx, n_sfx_idx;
    logic [SEQ_AW-1:0]  r_seq_addr, n_seq_addr;
    logic [LW_W-1:0]    r_line_cnt, n_line_cnt;
    logic [LW_W-1:0]    r_line_n, n_line_n;

    // Store ports.
    logic               name_we, name_re;
    logic [NAME_AW-1:0] name_waddr, name_raddr;
    logic [7:0]         name_rdata;
    logic               seq_we, seq_re;
    logic [SEQ_AW-1:0]  seq_waddr, seq_raddr;
    logic [7:0]         seq_wdata, seq_rdata;

    logic               w_slot_free;
    logic [LW_W-1:0]    w_width;
    logic [SEQ_CW-1:0]  w_left;
    logic [LW_W-1:0]    w_line_n;
    logic [SEQ_AW-1:0]  w_seq_start;
    logic [SEQ_CW-1:0]  w_rd_next;
    logic               w_name_end;
    logic               w_line_end;
    logic               w_done;
    logic [2:0]         w_st;

    frc_ram #(.WIDTH(8), .DEPTH(NAME_MAX)) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (name_waddr),
        .i_wdata (i_data_byte),
        .i_re    (name_re),
        .i_raddr (name_raddr),
        .o_rdata (name_rdata)
    );

    frc_ram #(.WIDTH(8), .DEPTH(SEQ_MAX)) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (seq_we),
        .i_waddr (seq_waddr),
        .i_wdata (seq_wdata),
        .i_re    (seq_re),
        .i_raddr (seq_raddr),
        .o_rdata (seq_rdata)
    );

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_width     = (r_lw == '0) ? LW_W'(1) : r_lw;
    assign w_left      = r_seq_count - r_rd_ptr;
    assign w_line_n    = (w_left < SEQ_CW'(w_width)) ? w_left[LW_W-1:0] : w_width;
    // Lines run backward from the newest stored byte not yet emitted.
    assign w_seq_start = SEQ_AW'(w_left - SEQ_CW'(1));
    assign w_rd_next   = r_rd_ptr + SEQ_CW'(r_line_n);
    assign w_name_end  = NAME_CW'(r_name_idx) == r_name_count - NAME_CW'(1);
    assign w_line_end  = r_line_cnt == r_line_n - LW_W'(1);

    assign name_waddr = NAME_AW'(r_name_count);
    assign seq_waddr  = SEQ_AW'(r_seq_count);
    assign seq_wdata  = complement_of(i_data_byte);

    always_comb begin
        o_sts              = '0;
        o_sts.slot_free    = w_slot_free;
        o_sts.error_flag   = r_error;
        o_sts.drain_active = r_drain;
        o_sts.header_sent  = r_hdr_sent;
        o_sts.name_empty   = r_name_count == '0;
        o_sts.name_end     = w_name_end;
        o_sts.sfx_end      = r_sfx_idx == SFX_IW'(SFX_LEN - 1);
        o_sts.line_end     = w_line_end;
    end

    always_comb begin
        n_lw          = r_lw;
        n_phase       = r_phase;
        n_line_start  = r_line_start;
        n_seq_started = r_seq_started;
        n_seq_count   = r_seq_count;
        n_name_count  = r_name_count;
        n_drain       = r_drain;
        n_hdr_sent    = r_hdr_sent;
        n_rd_ptr      = r_rd_ptr;
        n_error       = r_error;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_byte    = r_out_byte;
        n_out_last    = r_out_last;
        n_out_status  = r_out_status;
        n_out_done    = r_out_done;
        n_name_idx    = r_name_idx;
        n_sfx_idx     = r_sfx_idx;
        n_seq_addr    = r_seq_addr;
        n_line_cnt    = r_line_cnt;
        n_line_n      = r_line_n;
        name_we       = 1'b0;
        name_re       = 1'b0;
        name_raddr    = r_name_idx;
        seq_we        = 1'b0;
        seq_re        = 1'b0;
        seq_raddr     = r_seq_addr;
        w_done        = 1'b0;
        w_st          = ST_ACCEPTED;

        if (i_cfg_valid) begin
            n_lw = i_cfg_data;
        end

        if (i_cmd.single) begin
            if (r_error) begin
                w_st = ST_FORMAT;
            end else if (i_opcode == OP_PULL) begin
                w_st = ST_EMPTY;
            end else if (i_opcode == OP_PUSH || i_opcode == OP_END) begin
                if (r_drain) begin
                    w_st = ST_REFUSED;
                end else if (i_opcode == OP_PUSH) begin
                    unique case (r_phase)
                        PH_FIRST: begin
                            if (i_data_byte == CH_GT) begin
                                n_name_count = '0;
                                n_phase      = PH_HDR_PRE;
                                n_line_start = 1'b0;
                            end else begin
                                n_error = 1'b1;
                                w_st    = ST_FORMAT;
                            end
                        end
                        PH_HDR_PRE, PH_HDR_NAME: begin
                            if (i_data_byte == CH_NL) begin
                                n_phase      = PH_BODY;
                                n_line_start = 1'b1;
                            end else if (is_space(i_data_byte)) begin
                                if (r_phase == PH_HDR_NAME) begin
                                    n_phase = PH_HDR_REST;
                                end
                            end else begin
                                n_phase = PH_HDR_NAME;
                                if (r_name_count >= NAME_CW'(NAME_MAX)) begin
                                    w_st = ST_NAME_LONG;
                                end else begin
                                    name_we      = 1'b1;
                                    n_name_count = r_name_count + NAME_CW'(1);
                                end
                            end
                        end
                        PH_HDR_REST: begin
                            if (i_data_byte == CH_NL) begin
                                n_phase      = PH_BODY;
                                n_line_start = 1'b1;
                            end
                        end
                        default: begin
                            if (r_line_start && i_data_byte == CH_GT) begin
                                // A header before any sequence line is skipped.
                                if (r_seq_started) begin
                                    n_drain    = 1'b1;
                                    n_hdr_sent = 1'b0;
                                    n_rd_ptr   = '0;
                                    n_phase    = PH_PENDING;
                                end else begin
                                    n_phase = PH_HDR_REST;
                                end
                                n_line_start = 1'b0;
                            end else begin
                                n_seq_started = 1'b1;
                                if (i_data_byte == CH_NL) begin
                                    n_line_start = 1'b1;
                                end else begin
                                    n_line_start = 1'b0;
                                    if (r_seq_count >= SEQ_CW'(SEQ_MAX)) begin
                                        w_st = ST_SEQ_FULL;
                                    end else begin
                                        seq_we      = 1'b1;
                                        n_seq_count = r_seq_count + SEQ_CW'(1);
                                    end
                                end
                            end
                        end
                    endcase
                end else if (r_phase != PH_FIRST) begin
                    n_drain    = 1'b1;
                    n_hdr_sent = 1'b0;
                    n_rd_ptr   = '0;
                    n_phase    = PH_ENDED;
                end
            end
            n_out_valid  = 1'b1;
            n_out_byte   = 8'h00;
            n_out_last   = 1'b1;
            n_out_status = w_st;
            n_out_done   = 1'b0;
        end

        if (i_cmd.pull_start) begin
            n_sfx_idx = '0;
            if (!r_hdr_sent) begin
                name_re    = 1'b1;
                name_raddr = '0;
                n_name_idx = '0;
            end else begin
                seq_re     = 1'b1;
                seq_raddr  = w_seq_start;
                n_seq_addr = w_seq_start;
                n_line_cnt = '0;
                n_line_n   = w_line_n;
            end
        end

        if (i_cmd.emit) begin
            n_out_valid  = 1'b1;
            n_out_last   = 1'b0;
            n_out_status = ST_BYTE;
            n_out_done   = 1'b0;
            unique case (i_cmd.sel)
                SRC_GT: begin
                    n_out_byte = CH_GT;
                end
                SRC_NAME: begin
                    n_out_byte = name_rdata;
                    if (!w_name_end) begin
                        name_re    = 1'b1;
                        name_raddr = r_name_idx + NAME_AW'(1);
                        n_name_idx = r_name_idx + NAME_AW'(1);
                    end
                end
                SRC_SFX: begin
                    n_out_byte = sfx_byte(r_sfx_idx);
                    n_sfx_idx  = r_sfx_idx + SFX_IW'(1);
                end
                SRC_SEQ: begin
                    n_out_byte = seq_rdata;
                    if (!w_line_end) begin
                        seq_re     = 1'b1;
                        seq_raddr  = r_seq_addr - SEQ_AW'(1);
                        n_seq_addr = r_seq_addr - SEQ_AW'(1);
                        n_line_cnt = r_line_cnt + LW_W'(1);
                    end
                end
                default: begin
                    n_out_byte = CH_NL;
                    n_out_last = 1'b1;
                    if (!r_hdr_sent) begin
                        w_done     = r_seq_count == '0;
                        n_hdr_sent = 1'b1;
                    end else begin
                        w_done   = w_rd_next >= r_seq_count;
                        n_rd_ptr = w_rd_next;
                    end
                    n_out_done = w_done;
                    if (w_done) begin
                        n_drain       = 1'b0;
                        n_hdr_sent    = 1'b0;
                        n_rd_ptr      = '0;
                        n_seq_count   = '0;
                        n_seq_started = 1'b0;
                        n_name_count  = '0;
                        if (r_phase == PH_PENDING) begin
                            n_phase      = PH_HDR_PRE;
                            n_line_start = 1'b0;
                        end else begin
                            n_phase      = PH_FIRST;
                            n_line_start = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw          <= LW_RESET;
            r_phase       <= PH_FIRST;
            r_line_start  <= 1'b1;
            r_seq_started <= 1'b0;
            r_seq_count   <= '0;
            r_name_count  <= '0;
            r_drain       <= 1'b0;
            r_hdr_sent    <= 1'b0;
            r_rd_ptr      <= '0;
            r_error       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_lw          <= n_lw;
            r_phase       <= n_phase;
            r_line_start  <= n_line_start;
            r_seq_started <= n_seq_started;
            r_seq_count   <= n_seq_count;
            r_name_count  <= n_name_count;
            r_drain       <= n_drain;
            r_hdr_sent    <= n_hdr_sent;
            r_rd_ptr      <= n_rd_ptr;
            r_error       <= n_error;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_out_done   <= n_out_done;
        r_name_idx   <= n_name_idx;
        r_sfx_idx    <= n_sfx_idx;
        r_seq_addr   <= n_seq_addr;
        r_line_cnt   <= n_line_cnt;
        r_line_n     <= n_line_n;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_out_last    = r_out_last;
    assign o_status      = r_out_status;
    assign o_record_done = r_out_done;

`ifndef SYNTHESIS
    a_seq_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_count <= SEQ_CW'(SEQ_MAX))
        else $error("sequence count beyond the store depth");

    a_name_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_count <= NAME_CW'(NAME_MAX))
        else $error("name count beyond the name store depth");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain && r_hdr_sent) |-> (r_rd_ptr < r_seq_count))
        else $error("drain continues with no sequence bytes left");

    a_idle_pointers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_drain |-> (r_rd_ptr == '0 && !r_hdr_sent))
        else $error("drain pointers not cleared outside a drain");
`endif

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// FASTA reverse complement testbench
// Feeds FASTA text, end-of-input marks and line pulls into the block with
// random gaps and output stalls. A scoreboard mirrors the parser and the
// line emitter to predict every output beat, and checks each beat in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import frc_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RAND_ITEMS   = 230;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         CYCLE_LIMIT  = 2000000;

    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;

    typedef enum logic [2:0] {
        P_FIRST_HDR, P_HDR_LEAD, P_HDR_NAME, P_HDR_TAIL,
        P_BODY, P_NEXT_PENDING, P_INPUT_ENDED
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last;
        logic [2:0] status;
        logic       rec_done;
    } t_out_beat;

    class revcomp_scoreboard;
        t_out_beat    pending_beats[$];
        int           failures;
        t_parse_phase phase;
        bit           line_start, seq_started, draining, header_out, fmt_error;
        logic [7:0]   seq_mem[SEQ_MAX];
        logic [7:0]   name_mem[NAME_MAX];
        int           seq_cnt, name_cnt, rd_ptr, width;

        function new();
            failures    = 0;
            phase       = P_FIRST_HDR;
            line_start  = 1'b1;
            seq_started = 1'b0;
            draining    = 1'b0;
            header_out  = 1'b0;
            fmt_error   = 1'b0;
            seq_cnt     = 0;
            name_cnt    = 0;
            rd_ptr      = 0;
            width       = int'(LW_RESET);
        endfunction

        static function bit is_blank(logic [7:0] c);
            return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
        endfunction

        function logic [7:0] complement_base(logic [7:0] c);
            logic [7:0] u;
            u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
            case (u)
                "A": return "T";
                "C": return "G";
                "G": return "C";
                "T": return "A";
                "N": return "N";
                "-": return "-";
                default: return "?";
            endcase
        endfunction

        function void set_width(logic [LW_W-1:0] w);
            width = int'(w);
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction

        function bit at_first();
            return phase == P_FIRST_HDR;
        endfunction

        function bit is_draining();
            return draining;
        endfunction

        function void add(logic [7:0] b, logic l, logic [2:0] st, logic d);
            t_out_beat e;
            e = '{text_byte: b, last: l, status: st, rec_done: d};
            pending_beats.push_back(e);
        endfunction

        function void open_drain(t_parse_phase nxt);
            draining   = 1'b1;
            header_out = 1'b0;
            rd_ptr     = 0;
            phase      = nxt;
        endfunction

        function void close_drain();
            draining    = 1'b0;
            header_out  = 1'b0;
            rd_ptr      = 0;
            seq_cnt     = 0;
            seq_started = 1'b0;
            name_cnt    = 0;
            // A record closed by '>' has already consumed the next header's marker.
            if (phase == P_NEXT_PENDING) begin
                phase      = P_HDR_LEAD;
                line_start = 1'b0;
            end else begin
                phase      = P_FIRST_HDR;
                line_start = 1'b1;
            end
        endfunction

        function logic [2:0] parse_push(logic [7:0] c);
            case (phase)
                P_FIRST_HDR: begin
                    if (c == CH_GT) begin
                        name_cnt   = 0;
                        phase      = P_HDR_LEAD;
                        line_start = 1'b0;
                        return ST_ACCEPTED;
                    end
                    fmt_error = 1'b1;
                    return ST_FORMAT;
                end
                P_HDR_LEAD, P_HDR_NAME: begin
                    if (c == CH_NL) begin
                        phase      = P_BODY;
                        line_start = 1'b1;
                        return ST_ACCEPTED;
                    end
                    if (is_blank(c)) begin
                        if (phase == P_HDR_NAME) phase = P_HDR_TAIL;
                        return ST_ACCEPTED;
                    end
                    phase = P_HDR_NAME;
                    if (name_cnt >= NAME_MAX) return ST_NAME_LONG;
                    name_mem[name_cnt] = c;
                    name_cnt++;
                    return ST_ACCEPTED;
                end
                P_HDR_TAIL: begin
                    if (c == CH_NL) begin
                        phase      = P_BODY;
                        line_start = 1'b1;
                    end
                    return ST_ACCEPTED;
                end
                default: begin
                    if (line_start && c == CH_GT) begin
                        // A header before any sequence line is skipped.
                        if (seq_started) open_drain(P_NEXT_PENDING);
                        else phase = P_HDR_TAIL;
                        line_start = 1'b0;
                        return ST_ACCEPTED;
                    end
                    seq_started = 1'b1;
                    if (c == CH_NL) begin
                        line_start = 1'b1;
                        return ST_ACCEPTED;
                    end
                    line_start = 1'b0;
                    if (seq_cnt >= SEQ_MAX) return ST_SEQ_FULL;
                    seq_mem[seq_cnt] = complement_base(c);
                    seq_cnt++;
                    return ST_ACCEPTED;
                end
            endcase
        endfunction

        function void emit_line();
            string sfx;
            bit    fin;
            int    w, n, i;
            sfx = " revcompl";
            if (!header_out) begin
                add(CH_GT, 1'b0, ST_BYTE, 1'b0);
                for (i = 0; i < name_cnt; i++) add(name_mem[i], 1'b0, ST_BYTE, 1'b0);
                for (i = 0; i < sfx.len(); i++) add(sfx[i], 1'b0, ST_BYTE, 1'b0);
                header_out = 1'b1;
                fin = (seq_cnt == 0);
            end else begin
                w = (width == 0) ? 1 : width;
                n = (seq_cnt - rd_ptr < w) ? seq_cnt - rd_ptr : w;
                for (i = 0; i < n; i++) begin
                    add(seq_mem[seq_cnt - 1 - rd_ptr - i], 1'b0, ST_BYTE, 1'b0);
                end
                rd_ptr += n;
                fin = (rd_ptr >= seq_cnt);
            end
            add(CH_NL, 1'b1, ST_BYTE, fin);
            if (fin) close_drain();
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] c);
            logic [2:0] st;
            st = ST_ACCEPTED;
            if (fmt_error) begin
                add(8'h00, 1'b1, ST_FORMAT, 1'b0);
                return;
            end
            if (op == OP_PULL) begin
                if (!draining) add(8'h00, 1'b1, ST_EMPTY, 1'b0);
                else emit_line();
                return;
            end
            if (op == OP_PUSH || op == OP_END) begin
                if (draining) st = ST_REFUSED;
                else if (op == OP_PUSH) st = parse_push(c);
                else if (phase != P_FIRST_HDR) open_drain(P_INPUT_ENDED);
            end
            add(8'h00, 1'b1, st, 1'b0);
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat want;
            if (pending_beats.size() == 0) begin
                $error("unexpected output beat: out_byte %0h status %0d",
                       got.text_byte, got.status);
                failures++;
                return;
            end
            want = pending_beats.pop_front();
            if (got.text_byte !== want.text_byte) begin
                $error("out_byte: expected %0h, got %0h", want.text_byte, got.text_byte);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("out_last: expected %0b, got %0b", want.last, got.last);
                failures++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.rec_done !== want.rec_done) begin
                $error("record_done: expected %0b, got %0b", want.rec_done, got.rec_done);
                failures++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [1:0]        opcode    = OP_PUSH;
    logic [7:0]        data_byte = 8'h00;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [LW_W-1:0]   cfg_data  = '0;
    logic              in_stall;
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              out_last;
    logic [2:0]        status_code;
    logic              record_done;
    logic              cfg_ready;

    revcomp_scoreboard sb = new();
    int                item_count = 0;
    bit                idle_on = 1'b1;
    bit                hold_armed = 1'b0;

    fasta_reverse_complement dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_data_byte   (data_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_byte    (out_byte),
        .o_out_last    (out_last),
        .o_status      (status_code),
        .o_record_done (record_done),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin : cycle_guard
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Output side: checks each beat, then stalls for a random count. Once armed,
    // it holds off for a long stretch so that the block backs up into its input.
    initial begin : result_sink
        int        gap_left, hold_left;
        bit        hold_done, take, nxt;
        t_out_beat got;
        gap_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            take = (out_valid === 1'b1) && !out_stall;
            if (take) begin
                got = '{text_byte: out_byte, last: out_last, status: status_code,
                        rec_done: record_done};
                sb.check_beat(got);
                gap_left = idle_on ? $urandom_range(0, 8) : 0;
            end
            if (hold_armed && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            nxt = (hold_left > 0) || (gap_left > 0);
            if (hold_left > 0) hold_left--;
            else if (gap_left > 0) gap_left--;
            out_stall <= nxt;
            @(posedge clk);
        end
    end

    task automatic send(logic [1:0] op, logic [7:0] val);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= val;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_item(op, val);
        item_count++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) send(OP_PUSH, s[i]);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_line_width(logic [LW_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_width(w);
    endtask

    // Pulls lines until the record is out; now and then a push, an end mark or
    // the unused opcode slips in and must be refused or ignored.
    task automatic drain_all();
        logic [1:0] op;
        while (sb.is_draining()) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 2))
                    0: op = OP_PUSH;
                    1: op = OP_END;
                    default: op = OP_UNUSED;
                endcase
                send(op, 8'($urandom));
            end else begin
                send(OP_PULL, 8'($urandom));
            end
        end
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0: return CH_SP;
            1: return CH_TAB;
            2: return CH_CR;
            3: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] pick_token_byte();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_NL || revcomp_scoreboard::is_blank(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_text_byte();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_NL);
        return c;
    endfunction

    function automatic logic [7:0] pick_base(bit first);
        string      alphabet;
        logic [7:0] c;
        alphabet = "ACGTNacgtn-";
        if ($urandom_range(0, 7) != 0) return alphabet[$urandom_range(0, 10)];
        do c = 8'($urandom); while (c == CH_NL || (first && c == CH_GT));
        return c;
    endfunction

    // One well-formed record with random content, closed by '>' or by an end
    // mark, followed by its drain.
    task automatic gen_record();
        int nm_len, n_lines, len;
        if (sb.at_first()) send(OP_PUSH, CH_GT);
        repeat ($urandom_range(0, 2)) send(OP_PUSH, pick_blank());
        nm_len = ($urandom_range(0, 9) == 0) ? $urandom_range(44, 56) : $urandom_range(0, 10);
        repeat (nm_len) send(OP_PUSH, pick_token_byte());
        if ($urandom_range(0, 1) == 1) begin
            send(OP_PUSH, pick_blank());
            repeat ($urandom_range(0, 6)) send(OP_PUSH, pick_text_byte());
        end
        send(OP_PUSH, CH_NL);
        if ($urandom_range(0, 7) == 0) begin
            send(OP_PUSH, CH_GT);
            repeat ($urandom_range(0, 4)) send(OP_PUSH, pick_text_byte());
            send(OP_PUSH, CH_NL);
        end
        n_lines = $urandom_range(0, 4);
        repeat (n_lines) begin
            len = $urandom_range(0, 20);
            for (int k = 0; k < len; k++) send(OP_PUSH, pick_base(k == 0));
            send(OP_PUSH, CH_NL);
        end
        if ($urandom_range(0, 3) == 0) send(OP_END, 8'($urandom));
        else send(OP_PUSH, CH_GT);
        drain_all();
    endtask

    initial begin : stimulus
        logic [LW_W-1:0] w;
        int              target;
        logic [1:0]      op;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Items before any header, then a record with a skipped header, mixed
        // case, odd bytes and an empty line, closed by the next '>'.
        send(OP_END, 8'h00);
        send(OP_PULL, 8'hFF);
        send(OP_UNUSED, 8'hA5);
        push_text("> \tq1 d\n>s\nacgtN-z");
        send(OP_PUSH, 8'hFF);
        push_text("\n\n>");
        send(OP_PUSH, "A");
        send(OP_END, 8'h00);
        drain_all();
        // The next header has no token and no sequence before the end mark.
        send(OP_PUSH, CH_NL);
        send(OP_END, 8'h00);
        drain_all();

        // A width of zero behaves as one base per line.
        settle();
        write_line_width('0);
        push_text(">w0\nACG\n");
        send(OP_END, 8'h00);
        drain_all();

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: w = 6'd63;
                1: w = 6'd1;
                4: w = LW_RESET;
                default: w = LW_W'($urandom_range(2, 62));
            endcase
            write_line_width(w);
            if (ph == 1) hold_armed = 1'b1;
            target = item_count + RAND_ITEMS / 6;
            while (item_count < target) begin
                idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 2))
                        0: op = OP_PULL;
                        1: op = OP_END;
                        default: op = OP_UNUSED;
                    endcase
                    send(op, 8'($urandom));
                    drain_all();
                end
                gen_record();
            end
        end
        idle_on = 1'b1;
        if (!sb.at_first()) begin
            send(OP_END, 8'($urandom));
            drain_all();
        end

        // A first line without '>' locks the block into the format error.
        settle();
        send(OP_PUSH, "A");
        repeat (8) send(2'($urandom_range(0, 3)), 8'($urandom));

        settle();
        if (sb.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
